// File: src/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants for the circle collision pipeline
// Fixed-point formats, datapath widths and the side-band records that travel
// beside the square-root and divider cell rows.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 32;

    localparam int IN_CW  = 31;                 // centre coordinate width
    localparam int IN_RW  = 30;                 // radius width
    localparam int DIFF_W = 32;                 // centre difference width
    localparam int MAG_W  = 31;                 // magnitude of a difference
    localparam int SQ_W   = 2 * MAG_W;          // one square
    localparam int RAD_W  = 64;                 // radicand
    localparam int ROOT_W = RAD_W / 2;          // root bits, one per cell
    localparam int REM_W  = ROOT_W + 2;         // root remainder
    localparam int SUM_W  = IN_RW + 1;          // radius sum, depth
    localparam int K_W    = SUM_W + 2;          // signed radius minus depth
    localparam int QUO_W  = FRAC_BITS + 2;      // normal quotient, one per cell
    localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
    localparam int DREM_W = ROOT_W;             // divider remainder
    localparam int NRM_W  = FRAC_BITS + 2;      // signed normal component
    localparam int PROD_W = (FRAC_BITS + 1) + (K_W - 1);
    localparam int OFS_W  = PROD_W - FRAC_BITS + 1;
    localparam int ACC_W  = OFS_W + 2;

    localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_BITS;

    // Travels beside the square-root row
    typedef struct packed {
        logic [IN_CW-1:0] x1;
        logic [IN_CW-1:0] y1;
        logic [IN_RW-1:0] r1;
        logic [SUM_W-1:0] sum;
        logic [MAG_W-1:0] adx;
        logic [MAG_W-1:0] ady;
        logic             sx;
        logic             sy;
    } ccc_side_t;

    // Travels beside the divider row and the output stages
    typedef struct packed {
        logic [IN_CW-1:0]  x1;
        logic [IN_CW-1:0]  y1;
        logic [K_W-1:0]    k;
        logic [SUM_W-1:0]  depth;
        logic [ROOT_W-1:0] span;
        logic              collided;
        logic              zero;
        logic              sx;
        logic              sy;
    } ccc_mid_t;

endpackage

// File: src/ccc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ccc_sqrt_cell: one digit of an integer square root
// Takes two radicand bits, yields one root bit, hands all state onward.
// ----------------------------------------------------------------------------
module ccc_sqrt_cell
    import ccc_pkg::*;
(
    input  logic              aclk,
    input  logic              ce,
    input  logic [RAD_W-1:0]  rad_i,
    input  logic [REM_W-1:0]  rem_i,
    input  logic [ROOT_W-1:0] root_i,
    output logic [RAD_W-1:0]  rad_o,
    output logic [REM_W-1:0]  rem_o,
    output logic [ROOT_W-1:0] root_o
);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh, trial, diff;
    logic              ge;

    always_comb begin
        rem_sh    = {rem_i, rad_i[RAD_W-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_next = {root_i[ROOT_W-2:0], ge};
        rad_next  = {rad_i[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

// File: src/ccc_div_cell.sv
// ----------------------------------------------------------------------------
// ccc_div_cell: one step of a restoring divider
// Shifts in one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module ccc_div_cell
    import ccc_pkg::*;
(
    input  logic              aclk,
    input  logic              ce,
    input  logic [ROOT_W-1:0] divisor,
    input  logic [QUO_W-1:0]  bits_i,
    input  logic [DREM_W-1:0] rem_i,
    input  logic [QUO_W-1:0]  quo_i,
    output logic [QUO_W-1:0]  bits_o,
    output logic [DREM_W-1:0] rem_o,
    output logic [QUO_W-1:0]  quo_o
);

    logic [QUO_W-1:0]  bits_reg, bits_next;
    logic [DREM_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0]  quo_reg,  quo_next;
    logic [DREM_W:0]   trial, diff;
    logic              ge;

    always_comb begin
        trial     = {rem_i, bits_i[QUO_W-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        rem_next  = ge ? diff[DREM_W-1:0] : trial[DREM_W-1:0];
        quo_next  = {quo_i[QUO_W-2:0], ge};
        bits_next = {bits_i[QUO_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            bits_reg <= bits_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign bits_o = bits_reg;
    assign rem_o  = rem_reg;
    assign quo_o  = quo_reg;

endmodule

// File: src/circle_circle_collision.sv
// ----------------------------------------------------------------------------
// circle_circle_collision: streaming 2D circle-pair overlap test
// Centre distance by a row of root cells, normal by rows of divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries two circles (centres Q15.16 signed,
//   radii Q14.16 unsigned). Each request yields exactly one result on the m_
//   channel: m_tuser is the collided flag, m_tdata the unit normal, depth and
//   contact point. Without overlap every result field is zero.
// Pipeline: a request passes 57 register stages, the first loaded at the
//   accepting edge: the 32-cell square-root row (one root bit per cell), the
//   18-cell divider rows (one quotient bit per cell) and seven plain stages.
// Throughput: one request per cycle while the output is not stalled; every
//   stage holds a different request.
// Stall: the whole pipeline advances whenever the output register is empty
//   or being taken. While a result waits with m_tready low, every stage holds
//   and s_tready drops; bubbles ahead are not squeezed out.
// Reset: aresetn low clears all valid bits; no request is in flight after.
// ----------------------------------------------------------------------------
module circle_circle_collision
    import ccc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // first_x, first_y, first_radius, second_x, second_y, second_radius
    input  logic [183:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // normal_x, normal_y, depth, contact_x, contact_y, zero fill
    output logic [135:0] m_tdata,
    // collided
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = QUO_W;

    logic ce;

    // Advance everything unless a finished result is stuck at the output
    assign ce       = m_tready || !m_tvalid;
    assign s_tready = ce;

    // ---------------- stage 0: unpack, differences, radius sum ----------------
    logic [IN_CW-1:0] in_x1, in_y1, in_x2, in_y2;
    logic [IN_RW-1:0] in_r1, in_r2;

    assign in_x1 = s_tdata[30:0];
    assign in_y1 = s_tdata[61:31];
    assign in_r1 = s_tdata[91:62];
    assign in_x2 = s_tdata[122:92];
    assign in_y2 = s_tdata[153:123];
    assign in_r2 = s_tdata[183:154];

    logic              v0_reg;
    logic [IN_CW-1:0]  x1_s0_reg, y1_s0_reg;
    logic [IN_RW-1:0]  r1_s0_reg;
    logic [SUM_W-1:0]  sum_s0_reg;
    logic [DIFF_W-1:0] dx_s0_reg, dy_s0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
        end
        if (ce) begin
            x1_s0_reg  <= in_x1;
            y1_s0_reg  <= in_y1;
            r1_s0_reg  <= in_r1;
            sum_s0_reg <= {1'b0, in_r1} + {1'b0, in_r2};
            dx_s0_reg  <= {in_x2[IN_CW-1], in_x2} - {in_x1[IN_CW-1], in_x1};
            dy_s0_reg  <= {in_y2[IN_CW-1], in_y2} - {in_y1[IN_CW-1], in_y1};
        end
    end

    // ---------------- stage 1: magnitudes and squares ----------------
    logic [DIFF_W-1:0] adx_w, ady_w;
    logic              v1_reg;
    ccc_side_t         side_s1_reg;
    logic [SQ_W-1:0]   sqx_s1_reg, sqy_s1_reg;

    assign adx_w = dx_s0_reg[DIFF_W-1] ? (DIFF_W'(0) - dx_s0_reg) : dx_s0_reg;
    assign ady_w = dy_s0_reg[DIFF_W-1] ? (DIFF_W'(0) - dy_s0_reg) : dy_s0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= v0_reg;
        end
        if (ce) begin
            side_s1_reg.x1  <= x1_s0_reg;
            side_s1_reg.y1  <= y1_s0_reg;
            side_s1_reg.r1  <= r1_s0_reg;
            side_s1_reg.sum <= sum_s0_reg;
            side_s1_reg.adx <= adx_w[MAG_W-1:0];
            side_s1_reg.ady <= ady_w[MAG_W-1:0];
            side_s1_reg.sx  <= dx_s0_reg[DIFF_W-1];
            side_s1_reg.sy  <= dy_s0_reg[DIFF_W-1];
            sqx_s1_reg      <= adx_w[MAG_W-1:0] * adx_w[MAG_W-1:0];
            sqy_s1_reg      <= ady_w[MAG_W-1:0] * ady_w[MAG_W-1:0];
        end
    end

    // ---------------- stage 2: squared distance ----------------
    logic             v2_reg;
    ccc_side_t        side_s2_reg;
    logic [RAD_W-1:0] d2_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
        if (ce) begin
            side_s2_reg <= side_s1_reg;
            d2_s2_reg   <= RAD_W'(sqx_s1_reg) + RAD_W'(sqy_s1_reg);
        end
    end

    // ---------------- square-root row ----------------
    logic [RAD_W-1:0]  sq_rad  [0:SQ_N];
    logic [REM_W-1:0]  sq_rem  [0:SQ_N];
    logic [ROOT_W-1:0] sq_root [0:SQ_N];
    ccc_side_t         sq_side_reg [0:SQ_N-1];
    logic [SQ_N-1:0]   sq_v_reg;

    assign sq_rad[0]  = d2_s2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SQ_N; gi++) begin : g_sqrt
            ccc_sqrt_cell u_cell (
                .aclk   (aclk),
                .ce     (ce),
                .rad_i  (sq_rad[gi]),
                .rem_i  (sq_rem[gi]),
                .root_i (sq_root[gi]),
                .rad_o  (sq_rad[gi+1]),
                .rem_o  (sq_rem[gi+1]),
                .root_o (sq_root[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= '0;
        end else if (ce) begin
            sq_v_reg <= {sq_v_reg[SQ_N-2:0], v2_reg};
        end
        if (ce) begin
            sq_side_reg[0] <= side_s2_reg;
            for (int i = 1; i < SQ_N; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // ---------------- stage 3: overlap test, depth, dividends ----------------
    ccc_side_t         sq_out;
    logic [ROOT_W-1:0] dist_w;
    logic [SUM_W-1:0]  depth_w;
    logic [NUM_W-1:0]  numx_w, numy_w;
    logic              v3_reg;
    ccc_mid_t          mid_s3_reg;
    logic [NUM_W-1:0]  numx_s3_reg, numy_s3_reg;

    assign sq_out  = sq_side_reg[SQ_N-1];
    assign dist_w  = sq_root[SQ_N];
    assign depth_w = sq_out.sum - dist_w[SUM_W-1:0];
    assign numx_w  = {1'b0, sq_out.adx, FRAC_BITS'(0)} + NUM_W'(dist_w >> 1);
    assign numy_w  = {1'b0, sq_out.ady, FRAC_BITS'(0)} + NUM_W'(dist_w >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= sq_v_reg[SQ_N-1];
        end
        if (ce) begin
            mid_s3_reg.x1       <= sq_out.x1;
            mid_s3_reg.y1       <= sq_out.y1;
            mid_s3_reg.k        <= {3'b000, sq_out.r1} - {2'b00, depth_w};
            mid_s3_reg.depth    <= depth_w;
            mid_s3_reg.span     <= dist_w;
            mid_s3_reg.collided <= ({1'b0, sq_out.sum} > dist_w);
            mid_s3_reg.zero     <= (dist_w == '0);
            mid_s3_reg.sx       <= sq_out.sx;
            mid_s3_reg.sy       <= sq_out.sy;
            numx_s3_reg         <= numx_w;
            numy_s3_reg         <= numy_w;
        end
    end

    // ---------------- divider rows, x and y lanes ----------------
    // The quotient is at most one in Q.F, so the high dividend bits start
    // below the divisor and only QUO_W steps are needed.
    logic [QUO_W-1:0]  dvx_bits [0:DV_N];
    logic [DREM_W-1:0] dvx_rem  [0:DV_N];
    logic [QUO_W-1:0]  dvx_quo  [0:DV_N];
    logic [QUO_W-1:0]  dvy_bits [0:DV_N];
    logic [DREM_W-1:0] dvy_rem  [0:DV_N];
    logic [QUO_W-1:0]  dvy_quo  [0:DV_N];
    ccc_mid_t          dv_mid_reg [0:DV_N-1];
    logic [DV_N-1:0]   dv_v_reg;
    ccc_mid_t          dv_div [0:DV_N-1];

    assign dvx_bits[0] = numx_s3_reg[QUO_W-1:0];
    assign dvx_rem[0]  = DREM_W'(numx_s3_reg[NUM_W-1:QUO_W]);
    assign dvx_quo[0]  = '0;
    assign dvy_bits[0] = numy_s3_reg[QUO_W-1:0];
    assign dvy_rem[0]  = DREM_W'(numy_s3_reg[NUM_W-1:QUO_W]);
    assign dvy_quo[0]  = '0;

    assign dv_div[0] = mid_s3_reg;
    generate
        for (gi = 1; gi < DV_N; gi++) begin : g_dmid
            assign dv_div[gi] = dv_mid_reg[gi-1];
        end
        for (gi = 0; gi < DV_N; gi++) begin : g_div
            ccc_div_cell u_cell_x (
                .aclk    (aclk),
                .ce      (ce),
                .divisor (dv_div[gi].span),
                .bits_i  (dvx_bits[gi]),
                .rem_i   (dvx_rem[gi]),
                .quo_i   (dvx_quo[gi]),
                .bits_o  (dvx_bits[gi+1]),
                .rem_o   (dvx_rem[gi+1]),
                .quo_o   (dvx_quo[gi+1])
            );
            ccc_div_cell u_cell_y (
                .aclk    (aclk),
                .ce      (ce),
                .divisor (dv_div[gi].span),
                .bits_i  (dvy_bits[gi]),
                .rem_i   (dvy_rem[gi]),
                .quo_i   (dvy_quo[gi]),
                .bits_o  (dvy_bits[gi+1]),
                .rem_o   (dvy_rem[gi+1]),
                .quo_o   (dvy_quo[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg <= '0;
        end else if (ce) begin
            dv_v_reg <= {dv_v_reg[DV_N-2:0], v3_reg};
        end
        if (ce) begin
            dv_mid_reg[0] <= mid_s3_reg;
            for (int i = 1; i < DV_N; i++) begin
                dv_mid_reg[i] <= dv_mid_reg[i-1];
            end
        end
    end

    // ---------------- stage 4: clamp and sign the normal ----------------
    ccc_mid_t         dv_out;
    logic [QUO_W-1:0] qx_w, qy_w;
    logic [NRM_W-1:0] nx_w, ny_w;
    logic             v4_reg;
    ccc_mid_t         mid_s4_reg;
    logic [NRM_W-1:0] nx_s4_reg, ny_s4_reg;

    assign dv_out = dv_mid_reg[DV_N-1];
    assign qx_w   = (dvx_quo[DV_N] > ONE_Q) ? ONE_Q : dvx_quo[DV_N];
    assign qy_w   = (dvy_quo[DV_N] > ONE_Q) ? ONE_Q : dvy_quo[DV_N];

    always_comb begin
        if (dv_out.zero) begin
            // Coincident centres: point straight up
            nx_w = '0;
            ny_w = NRM_W'(ONE_Q);
        end else begin
            nx_w = dv_out.sx ? (NRM_W'(0) - NRM_W'(qx_w)) : NRM_W'(qx_w);
            ny_w = dv_out.sy ? (NRM_W'(0) - NRM_W'(qy_w)) : NRM_W'(qy_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= dv_v_reg[DV_N-1];
        end
        if (ce) begin
            mid_s4_reg <= dv_out;
            nx_s4_reg  <= nx_w;
            ny_s4_reg  <= ny_w;
        end
    end

    // ---------------- stage 5: normal times lever ----------------
    logic [NRM_W-2:0]  anx_w, any_w;
    logic [K_W-2:0]    ak_w;
    logic [NRM_W-1:0]  tx_w, ty_w;
    logic [K_W-1:0]    tk_w;
    logic              v5_reg;
    ccc_mid_t          mid_s5_reg;
    logic [NRM_W-1:0]  nx_s5_reg, ny_s5_reg;
    logic [PROD_W-1:0] px_s5_reg, py_s5_reg;
    logic              negx_s5_reg, negy_s5_reg;

    assign tx_w  = nx_s4_reg[NRM_W-1] ? (NRM_W'(0) - nx_s4_reg) : nx_s4_reg;
    assign ty_w  = ny_s4_reg[NRM_W-1] ? (NRM_W'(0) - ny_s4_reg) : ny_s4_reg;
    assign tk_w  = mid_s4_reg.k[K_W-1] ? (K_W'(0) - mid_s4_reg.k) : mid_s4_reg.k;
    assign anx_w = tx_w[NRM_W-2:0];
    assign any_w = ty_w[NRM_W-2:0];
    assign ak_w  = tk_w[K_W-2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ce) begin
            v5_reg <= v4_reg;
        end
        if (ce) begin
            mid_s5_reg  <= mid_s4_reg;
            nx_s5_reg   <= nx_s4_reg;
            ny_s5_reg   <= ny_s4_reg;
            px_s5_reg   <= anx_w * ak_w;
            py_s5_reg   <= any_w * ak_w;
            negx_s5_reg <= nx_s4_reg[NRM_W-1] ^ mid_s4_reg.k[K_W-1];
            negy_s5_reg <= ny_s4_reg[NRM_W-1] ^ mid_s4_reg.k[K_W-1];
        end
    end

    // ---------------- stage 6: round, offset, saturate, output ----------------
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [PROD_W:0]          rx_full, ry_full;
    logic [OFS_W-1:0]         rx_w, ry_w;
    logic signed [ACC_W-1:0]  sx_w, sy_w;
    logic [COORD_BITS-1:0]    cx_w, cy_w;

    assign rx_full = ({1'b0, px_s5_reg} + HALF) >> FRAC_BITS;
    assign ry_full = ({1'b0, py_s5_reg} + HALF) >> FRAC_BITS;
    assign rx_w    = rx_full[OFS_W-1:0];
    assign ry_w    = ry_full[OFS_W-1:0];

    always_comb begin
        sx_w = $signed(ACC_W'($signed(mid_s5_reg.x1)))
             + (negx_s5_reg ? -$signed(ACC_W'(rx_w)) : $signed(ACC_W'(rx_w)));
        sy_w = $signed(ACC_W'($signed(mid_s5_reg.y1)))
             + (negy_s5_reg ? -$signed(ACC_W'(ry_w)) : $signed(ACC_W'(ry_w)));
        if (sx_w > SAT_HI) begin
            cx_w = SAT_HI[COORD_BITS-1:0];
        end else if (sx_w < SAT_LO) begin
            cx_w = SAT_LO[COORD_BITS-1:0];
        end else begin
            cx_w = sx_w[COORD_BITS-1:0];
        end
        if (sy_w > SAT_HI) begin
            cy_w = SAT_HI[COORD_BITS-1:0];
        end else if (sy_w < SAT_LO) begin
            cy_w = SAT_LO[COORD_BITS-1:0];
        end else begin
            cy_w = sy_w[COORD_BITS-1:0];
        end
    end

    logic                  out_v_reg;
    logic                  hit_reg;
    logic [NRM_W-1:0]      onx_reg, ony_reg;
    logic [SUM_W-1:0]      odepth_reg;
    logic [COORD_BITS-1:0] ocx_reg, ocy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (ce) begin
            out_v_reg <= v5_reg;
        end
        if (ce) begin
            // Drop every field to zero when the circles do not overlap
            hit_reg    <= mid_s5_reg.collided;
            onx_reg    <= mid_s5_reg.collided ? nx_s5_reg : '0;
            ony_reg    <= mid_s5_reg.collided ? ny_s5_reg : '0;
            odepth_reg <= mid_s5_reg.collided ? mid_s5_reg.depth : '0;
            ocx_reg    <= mid_s5_reg.collided ? cx_w : '0;
            ocy_reg    <= mid_s5_reg.collided ? cy_w : '0;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tuser[0] = hit_reg;
    assign m_tdata    = {5'b00000, ocy_reg, ocx_reg, odepth_reg, ony_reg, onx_reg};

endmodule

// File: dv/circle_circle_collision_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_circle_collision_tb: self-checking bench for the circle overlap pipe
// Drives directed and random circle pairs with random gaps, predicts each result with an
// independent fixed-point model, and compares results in order.
// ----------------------------------------------------------------------------

class overlap_scoreboard;
    typedef struct {
        logic        collided;
        logic [17:0] nx;
        logic [17:0] ny;
        logic [30:0] depth;
        logic [31:0] cx;
        logic [31:0] cy;
    } contact_t;

    contact_t pending[$];
    int       errors;
    int       hits;
    int       seen;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   -= res + bit_w;
                res  = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint d, longint unsigned span);
        longint unsigned q;
        longint unsigned m;
        m = (d < 0) ? -d : d;
        q = ((m << 16) + span / 2) / span;
        if (q > 65536) q = 65536;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint touch_coord(longint ctr, longint n, longint k);
        longint unsigned p;
        longint unsigned r;
        longint          s;
        p = longint'((n < 0) ? -n : n) * longint'((k < 0) ? -k : k);
        r = (p + 32768) >> 16;
        s = ctr + (((n < 0) != (k < 0)) ? -longint'(r) : longint'(r));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [183:0] d);
        longint          x1, y1, r1, x2, y2, r2, dx, dy, k, nx, ny, dep;
        longint unsigned d2, span, sum;
        contact_t        e;
        x1 = longint'($signed(d[30:0]));
        y1 = longint'($signed(d[61:31]));
        r1 = longint'(d[91:62]);
        x2 = longint'($signed(d[122:92]));
        y2 = longint'($signed(d[153:123]));
        r2 = longint'(d[183:154]);
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = longint'((dx < 0) ? -dx : dx) * longint'((dx < 0) ? -dx : dx)
           + longint'((dy < 0) ? -dy : dy) * longint'((dy < 0) ? -dy : dy);
        span = root_floor(d2);
        sum  = r1 + r2;
        e = '{1'b0, '0, '0, '0, '0, '0};
        if (span < sum) begin
            if (d2 == 0) begin
                nx = 0;
                ny = 65536;
            end else begin
                nx = unit_part(dx, span);
                ny = unit_part(dy, span);
            end
            dep = sum - span;
            k   = r1 - dep;
            e.collided = 1'b1;
            e.nx    = nx[17:0];
            e.ny    = ny[17:0];
            e.depth = dep[30:0];
            e.cx    = 32'(touch_coord(x1, nx, k));
            e.cy    = 32'(touch_coord(y1, ny, k));
        end
        pending.push_back(e);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [135:0] d, logic col);
        contact_t e;
        seen++;
        if (pending.size() == 0) begin
            $error("unexpected result with nothing pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.collided) hits++;
        if (col !== e.collided) begin
            $error("collided exp %0d got %0d", e.collided, col); errors++;
        end
        if (d[17:0] !== e.nx) begin
            $error("normal_x exp %0h got %0h", e.nx, d[17:0]); errors++;
        end
        if (d[35:18] !== e.ny) begin
            $error("normal_y exp %0h got %0h", e.ny, d[35:18]); errors++;
        end
        if (d[66:36] !== e.depth) begin
            $error("depth exp %0h got %0h", e.depth, d[66:36]); errors++;
        end
        if (d[98:67] !== e.cx) begin
            $error("contact_x exp %0h got %0h", e.cx, d[98:67]); errors++;
        end
        if (d[130:99] !== e.cy) begin
            $error("contact_y exp %0h got %0h", e.cy, d[130:99]); errors++;
        end
    endfunction
endclass

module circle_circle_collision_tb;
    import ccc_pkg::*;

    localparam int  LATENCY   = 57;
    localparam longint LIMIT  = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [183:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    overlap_scoreboard board = new();
    longint cycles = 0;
    bit     calm = 1'b0;   // hold both sides busy for a stretch
    int     sent = 0;

    circle_circle_collision dut (.*);

    always #2 aclk = ~aclk;

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, check on each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
        m_tready <= aresetn && (calm || $urandom_range(99) >= 17);
    end

    function automatic logic [30:0] rnd_coord();
        case ($urandom_range(5))
            0: return 31'h40000000;
            1: return 31'h3fffffff;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [29:0] rnd_radius();
        case ($urandom_range(4))
            0: return 30'h3fffffff;
            1: return 30'($urandom_range(65536 * 8));
            default: return 30'($urandom);
        endcase
    endfunction

    // present one request, hold it until accepted; idle gaps at random
    task automatic send_pair(logic [30:0] x1, logic [30:0] y1, logic [29:0] r1,
                             logic [30:0] x2, logic [30:0] y2, logic [29:0] r2);
        while (!calm && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {r2, y2, x2, r1, y1, x1};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request({r2, y2, x2, r1, y1, x1});
        sent++;
    endtask

    // random pair, mostly near enough to overlap
    task automatic send_random();
        logic [30:0] x1, y1, x2, y2;
        logic [29:0] r1, r2;
        x1 = rnd_coord();
        y1 = rnd_coord();
        r1 = rnd_radius();
        r2 = rnd_radius();
        if ($urandom_range(3) != 0) begin
            x2 = x1 + 31'($signed(20'($urandom)) <<< $urandom_range(10));
            y2 = y1 + 31'($signed(20'($urandom)) <<< $urandom_range(10));
        end else begin
            x2 = rnd_coord();
            y2 = rnd_coord();
        end
        send_pair(x1, y1, r1, x2, y2, r2);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: coincident centres, touching, extremes, axis normals
        send_pair('0, '0, 30'h10000, '0, '0, 30'h10000);
        send_pair('0, '0, '0, '0, '0, '0);
        send_pair('0, '0, 30'h10000, 31'h20000, '0, 30'h10000);
        send_pair('0, '0, 30'h10000, 31'h1ffff, '0, 30'h10000);
        send_pair('0, '0, 30'h10000, '0, -31'sd65536, 30'h10000);
        send_pair(31'h40000000, 31'h40000000, 30'h3fffffff,
                  31'h3fffffff, 31'h3fffffff, 30'h3fffffff);
        send_pair(31'h3fffffff, 31'h3fffffff, 30'h3fffffff,
                  31'h40000000, 31'h40000000, 30'h3fffffff);
        send_pair(31'h3fffffff, '0, 30'h3fffffff, 31'h3fffffff, '0, 30'h3fffffff);
        send_pair(31'h40000000, '0, 30'h3fffffff, 31'h40000000, 31'h10, 30'h3fffffff);
        send_pair(31'h7fffffff, 31'h7fffffff, 30'h1, '0, '0, 30'h3fffffff);
        send_pair('0, '0, 30'h5, 31'h3, 31'h4, 30'h1);
        send_pair(31'h40000000, 31'h3fffffff, 30'h2aaaaaaa,
                  31'h3fffffff, 31'h40000000, 30'h15555555);
        send_pair(31'h1234567, 31'h7654321, '0, 31'h1234567, 31'h7654321, 30'h1);

        // wait for the pipe to drain before going on
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);

        for (int i = 0; i < 700; i++) begin
            calm = (i >= 300 && i < 420);
            send_random();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d circle pairs, %0d results checked, %0d overlapping.",
                 sent, board.seen, board.hits);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
